// File: rtl/core/rsc_pkg.sv
package rsc_pkg;

    localparam int MASK_BITS     = 16;
    localparam int MASK_IDX_BITS = 4;
    localparam int SLOT_EXT_BITS = 7;
    localparam int CFG_BITS      = 8;
    localparam int SLOT_OUT_BITS = 5;

    localparam logic [31:0]         AGE_LIMIT         = 32'h7FFF_FFFF;
    localparam logic [CFG_BITS-1:0] PENDING_LIMIT_RST = 8'd10;
    localparam logic [CFG_BITS-1:0] BYPASS_ID_RST     = 8'h1F;

    typedef enum logic [0:0] {
        CFG_PENDING_LIMIT = 1'b0,
        CFG_BYPASS_ID     = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } rsc_state_t;

    // one read beat coming back from the tag memory
    typedef struct packed {
        logic clear;
        logic beat;
        logic entry_valid;
        logic pinned;
    } scan_ctl_t;

    typedef struct packed {
        logic hit_found;
        logic empty_found;
        logic pick_found;
    } scan_stat_t;

    typedef struct packed {
        logic [SLOT_OUT_BITS-1:0] slot_index;
        logic                     failed;
        logic                     hit;
        logic                     loaded;
        logic                     evicted;
        logic                     miss_seen;
        logic                     clear_req_slot;
        logic                     clear_req_busy;
    } rsc_result_t;

endpackage

// File: rtl/core/rsc_if.sv
interface rsc_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  res_id;
    logic        res_valid;
    logic        loading_blocked;
    logic [7:0]  pending_count;
    logic [31:0] current_time;
    logic [15:0] pinned_mask;
    logic [15:0] slot_busy_mask;
    logic        requester_busy;

    modport source (
        output valid, res_id, res_valid, loading_blocked, pending_count,
               current_time, pinned_mask, slot_busy_mask, requester_busy,
        input  ready
    );
    modport sink (
        input  valid, res_id, res_valid, loading_blocked, pending_count,
               current_time, pinned_mask, slot_busy_mask, requester_busy,
        output ready
    );
endinterface

interface rsc_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] slot_index;
    logic       failed;
    logic       hit;
    logic       loaded;
    logic       evicted;
    logic       miss_seen;
    logic       clear_req_slot;
    logic       clear_req_busy;

    modport source (
        output valid, slot_index, failed, hit, loaded, evicted, miss_seen,
               clear_req_slot, clear_req_busy,
        input  ready
    );
    modport sink (
        input  valid, slot_index, failed, hit, loaded, evicted, miss_seen,
               clear_req_slot, clear_req_busy,
        output ready
    );
endinterface

// File: rtl/core/rsc_tag_mem.sv
module rsc_tag_mem #(
    parameter int SLOTS     = 16,
    parameter int ID_BITS   = 8,
    parameter int AGE_BITS  = 32,
    parameter int SLOT_BITS = 4
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [SLOT_BITS-1:0] wr_addr,
    input  logic [ID_BITS-1:0]   wr_id,
    input  logic [AGE_BITS-1:0]  wr_age,
    input  logic                 rd_en,
    input  logic [SLOT_BITS-1:0] rd_addr,
    output logic [ID_BITS-1:0]   rd_id,
    output logic [AGE_BITS-1:0]  rd_age
);

    logic [ID_BITS-1:0]  id_mem  [SLOTS];
    logic [AGE_BITS-1:0] age_mem [SLOTS];
    logic [ID_BITS-1:0]  rd_id_reg;
    logic [AGE_BITS-1:0] rd_age_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]  <= wr_id;
            age_mem[wr_addr] <= wr_age;
        end
        if (rd_en)
        begin
            rd_id_reg  <= id_mem[rd_addr];
            rd_age_reg <= age_mem[rd_addr];
        end
    end

    assign rd_id  = rd_id_reg;
    assign rd_age = rd_age_reg;

endmodule

// File: rtl/core/rsc_scan.sv
module rsc_scan
    import rsc_pkg::*;
#(
    parameter int ID_BITS   = 8,
    parameter int AGE_BITS  = 32,
    parameter int SLOT_BITS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scan_ctl_t            ctl,
    input  logic [SLOT_BITS-1:0] beat_slot,
    input  logic [ID_BITS-1:0]   req_id,
    input  logic [ID_BITS-1:0]   rd_id,
    input  logic [AGE_BITS-1:0]  rd_age,
    output scan_stat_t           stat,
    output logic [SLOT_BITS-1:0] hit_slot,
    output logic [SLOT_BITS-1:0] empty_slot,
    output logic [SLOT_BITS-1:0] pick_slot
);

    logic                 hit_found_reg;
    logic                 empty_found_reg;
    logic                 pick_found_reg;
    logic [SLOT_BITS-1:0] hit_slot_reg;
    logic [SLOT_BITS-1:0] empty_slot_reg;
    logic [SLOT_BITS-1:0] pick_slot_reg;
    logic [AGE_BITS-1:0]  best_age_reg;
    logic [31:0]          age_ext;
    logic                 take_hit;
    logic                 take_empty;
    logic                 take_pick;

    always_comb
    begin
        age_ext    = 32'(rd_age);
        take_hit   = ctl.beat && ctl.entry_valid && !hit_found_reg && (rd_id == req_id);
        take_empty = ctl.beat && !ctl.entry_valid && !empty_found_reg;
        // strict compare in ascending order keeps ties on the lowest slot
        take_pick  = ctl.beat && ctl.entry_valid && !ctl.pinned && (age_ext < AGE_LIMIT)
                     && (!pick_found_reg || (rd_age < best_age_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            pick_found_reg  <= 1'b0;
        end
        else if (ctl.clear)
        begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            pick_found_reg  <= 1'b0;
        end
        else
        begin
            if (take_hit)
                hit_found_reg <= 1'b1;
            if (take_empty)
                empty_found_reg <= 1'b1;
            if (take_pick)
                pick_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_hit)
            hit_slot_reg <= beat_slot;
        if (take_empty)
            empty_slot_reg <= beat_slot;
        if (take_pick)
        begin
            pick_slot_reg <= beat_slot;
            best_age_reg  <= rd_age;
        end
    end

    assign stat.hit_found   = hit_found_reg;
    assign stat.empty_found = empty_found_reg;
    assign stat.pick_found  = pick_found_reg;
    assign hit_slot         = hit_slot_reg;
    assign empty_slot       = empty_slot_reg;
    assign pick_slot        = pick_slot_reg;

endmodule

// File: rtl/core/rsc_ctrl.sv
module rsc_ctrl
    import rsc_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int ID_BITS   = 8,
    parameter int AGE_BITS  = 32,
    parameter int SLOT_BITS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_wdata,
    rsc_req_if.sink              req,
    rsc_rsp_if.source            rsp,
    output logic                 rd_en,
    output logic [SLOT_BITS-1:0] rd_addr,
    output logic                 wr_en,
    output logic [SLOT_BITS-1:0] wr_addr,
    output logic [ID_BITS-1:0]   wr_id,
    output logic [AGE_BITS-1:0]  wr_age,
    output scan_ctl_t            scan_ctl,
    output logic [SLOT_BITS-1:0] beat_slot,
    output logic [ID_BITS-1:0]   req_id,
    input  scan_stat_t           stat,
    input  logic [SLOT_BITS-1:0] hit_slot,
    input  logic [SLOT_BITS-1:0] empty_slot,
    input  logic [SLOT_BITS-1:0] pick_slot
);

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    rsc_state_t state_reg, state_next;

    logic [CFG_BITS-1:0]  pending_limit_reg;
    logic [CFG_BITS-1:0]  bypass_id_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [AGE_BITS-1:0]  now_reg;
    logic [MASK_BITS-1:0] pinned_reg;
    logic [MASK_BITS-1:0] busy_reg;
    logic                 req_busy_reg;
    logic                 miss_fail_reg;
    logic [SLOT_BITS-1:0] addr_reg;
    logic                 beat_reg;
    logic [SLOT_BITS-1:0] beat_slot_reg;
    logic                 beat_valid_reg;
    logic                 beat_pinned_reg;
    logic [SLOTS-1:0]     valid_reg;
    rsc_result_t          pend_reg;
    rsc_result_t          out_reg;
    logic                 out_valid_reg;

    logic                     accept;
    logic                     is_bypass;
    logic                     out_free;
    logic                     pin_bit;
    logic                     busy_bit;
    logic [SLOT_EXT_BITS-1:0] addr_w;
    logic [SLOT_EXT_BITS-1:0] pick_w;
    logic                     load_slot;
    logic [SLOT_BITS-1:0]     load_addr;
    rsc_result_t              dec_res;
    rsc_result_t              early_res;

    assign accept    = req.valid && req.ready;
    assign is_bypass = (req.res_id == bypass_id_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (is_bypass || !req.res_valid) ? ST_EMIT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (addr_reg == LAST_SLOT)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // decision over the scan result
    always_comb
    begin
        pick_w    = SLOT_EXT_BITS'(pick_slot);
        busy_bit  = (pick_w < SLOT_EXT_BITS'(MASK_BITS)) && busy_reg[pick_w[MASK_IDX_BITS-1:0]];
        dec_res   = '0;
        load_slot = 1'b0;
        load_addr = pick_slot;
        priority if (stat.hit_found)
        begin
            dec_res.slot_index     = SLOT_OUT_BITS'(hit_slot);
            dec_res.hit            = 1'b1;
            dec_res.clear_req_slot = !req_busy_reg;
        end
        else if (miss_fail_reg)
        begin
            dec_res.failed    = 1'b1;
            dec_res.miss_seen = 1'b1;
        end
        else if (stat.empty_found)
        begin
            load_slot              = 1'b1;
            load_addr              = empty_slot;
            dec_res.slot_index     = SLOT_OUT_BITS'(empty_slot);
            dec_res.loaded         = 1'b1;
            dec_res.miss_seen      = 1'b1;
            dec_res.clear_req_slot = !req_busy_reg;
        end
        else if (!stat.pick_found || busy_bit)
        begin
            dec_res.failed    = 1'b1;
            dec_res.miss_seen = 1'b1;
        end
        else
        begin
            load_slot              = 1'b1;
            dec_res.slot_index     = SLOT_OUT_BITS'(pick_slot);
            dec_res.loaded         = 1'b1;
            dec_res.evicted        = 1'b1;
            dec_res.miss_seen      = 1'b1;
            dec_res.clear_req_slot = 1'b1;
            dec_res.clear_req_busy = 1'b1;
        end
    end

    // state outputs
    always_comb
    begin
        addr_w    = SLOT_EXT_BITS'(addr_reg);
        pin_bit   = (addr_w < SLOT_EXT_BITS'(MASK_BITS)) && pinned_reg[addr_w[MASK_IDX_BITS-1:0]];
        req.ready = (state_reg == ST_IDLE);
        rd_en     = (state_reg == ST_SCAN);
        wr_en     = (state_reg == ST_DECIDE) && load_slot;
        early_res = '0;
        if (is_bypass)
            early_res.slot_index = SLOT_OUT_BITS'(SLOTS);
        else
            early_res.failed = 1'b1;
    end

    assign rd_addr  = addr_reg;
    assign wr_addr  = load_addr;
    assign wr_id    = id_reg;
    assign wr_age   = now_reg;
    assign req_id   = id_reg;
    assign beat_slot = beat_slot_reg;

    assign scan_ctl.clear       = (state_reg == ST_IDLE);
    assign scan_ctl.beat        = beat_reg;
    assign scan_ctl.entry_valid = beat_valid_reg;
    assign scan_ctl.pinned      = beat_pinned_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pending_limit_reg <= PENDING_LIMIT_RST;
            bypass_id_reg     <= BYPASS_ID_RST;
            addr_reg          <= '0;
            beat_reg          <= 1'b0;
            valid_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PENDING_LIMIT: pending_limit_reg <= cfg_wdata;
                    CFG_BYPASS_ID:     bypass_id_reg     <= cfg_wdata;
                    default:           ;
                endcase
            end
            if (state_reg == ST_SCAN)
                addr_reg <= addr_reg + SLOT_BITS'(1);
            else
                addr_reg <= '0;
            beat_reg <= rd_en;
            if (wr_en)
                valid_reg[load_addr] <= 1'b1;
            if ((state_reg == ST_EMIT) && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg        <= ID_BITS'(req.res_id);
            now_reg       <= AGE_BITS'(req.current_time);
            pinned_reg    <= req.pinned_mask;
            busy_reg      <= req.slot_busy_mask;
            req_busy_reg  <= req.requester_busy;
            miss_fail_reg <= req.loading_blocked || (req.pending_count >= pending_limit_reg);
            pend_reg      <= early_res;
        end
        else if (state_reg == ST_DECIDE)
            pend_reg <= dec_res;
        beat_slot_reg   <= addr_reg;
        beat_valid_reg  <= valid_reg[addr_reg];
        beat_pinned_reg <= pin_bit;
        if ((state_reg == ST_EMIT) && out_free)
            out_reg <= pend_reg;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.slot_index     = out_reg.slot_index;
    assign rsp.failed         = out_reg.failed;
    assign rsp.hit            = out_reg.hit;
    assign rsp.loaded         = out_reg.loaded;
    assign rsp.evicted        = out_reg.evicted;
    assign rsp.miss_seen      = out_reg.miss_seen;
    assign rsp.clear_req_slot = out_reg.clear_req_slot;
    assign rsp.clear_req_busy = out_reg.clear_req_busy;

endmodule

// File: rtl/core/resource_slot_cache_oldest_replace_unit.sv
// resource slot cache, fully associative, oldest load age replaced
//
// req channel: one beat per request (resource id, validity, load gating,
// time stamp, pinned and busy masks). rsp channel: one beat per request with
// the resolved slot and the hit / loaded / evicted / miss / clear marks.
// cfg port: cfg_we with cfg_index 0 writes pending_limit, 1 writes bypass_id.
//
// a request is taken only when the unit is idle. the bypass id and invalid
// resources go straight to the emit state; any other request walks the tag
// memory one slot per cycle, then passes the drain and decide states before
// it is answered, and the next request can be taken in the cycle that the
// answer is presented. the single read port of the tag memory is why the
// walk reads one slot at a time.
// reset empties all slots and loads pending_limit 10 and bypass_id 0x1F.
// the result sits in an output register; while rsp is stalled a new request
// can still be taken and scanned, and it then waits for that register.
module resource_slot_cache_oldest_replace_unit
    import rsc_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int ID_BITS  = 8,
    parameter int AGE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    rsc_req_if.sink             req,
    rsc_rsp_if.source           rsp
);

    localparam int SLOT_BITS = $clog2(SLOTS);

    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    logic [ID_BITS-1:0]   wr_id;
    logic [AGE_BITS-1:0]  wr_age;
    logic [ID_BITS-1:0]   rd_id;
    logic [AGE_BITS-1:0]  rd_age;
    scan_ctl_t            scan_ctl;
    scan_stat_t           stat;
    logic [SLOT_BITS-1:0] beat_slot;
    logic [ID_BITS-1:0]   req_id;
    logic [SLOT_BITS-1:0] hit_slot;
    logic [SLOT_BITS-1:0] empty_slot;
    logic [SLOT_BITS-1:0] pick_slot;

    rsc_ctrl #(
        .SLOTS     (SLOTS),
        .ID_BITS   (ID_BITS),
        .AGE_BITS  (AGE_BITS),
        .SLOT_BITS (SLOT_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .rsp        (rsp),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_id      (wr_id),
        .wr_age     (wr_age),
        .scan_ctl   (scan_ctl),
        .beat_slot  (beat_slot),
        .req_id     (req_id),
        .stat       (stat),
        .hit_slot   (hit_slot),
        .empty_slot (empty_slot),
        .pick_slot  (pick_slot)
    );

    rsc_tag_mem #(
        .SLOTS     (SLOTS),
        .ID_BITS   (ID_BITS),
        .AGE_BITS  (AGE_BITS),
        .SLOT_BITS (SLOT_BITS)
    ) u_tag_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_id   (wr_id),
        .wr_age  (wr_age),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_id   (rd_id),
        .rd_age  (rd_age)
    );

    rsc_scan #(
        .ID_BITS   (ID_BITS),
        .AGE_BITS  (AGE_BITS),
        .SLOT_BITS (SLOT_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .beat_slot  (beat_slot),
        .req_id     (req_id),
        .rd_id      (rd_id),
        .rd_age     (rd_age),
        .stat       (stat),
        .hit_slot   (hit_slot),
        .empty_slot (empty_slot),
        .pick_slot  (pick_slot)
    );

`ifndef SYNTHESIS
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> !rsp.failed && !rsp.loaded && !rsp.miss_seen)
        else $error("hit beat carries miss or load marks");

    a_load_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.loaded |-> rsp.miss_seen && !rsp.failed)
        else $error("load without miss");

    a_evict_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.evicted |-> rsp.loaded && rsp.clear_req_slot && rsp.clear_req_busy)
        else $error("eviction without requester clear");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while busy");
`endif

endmodule

// File: bench/resource_slot_cache_oldest_replace_unit_test.sv
module resource_slot_cache_oldest_replace_unit_test;
    import rsc_pkg::*;

    localparam int SLOTS           = 16;
    localparam int ID_BITS         = 8;
    localparam int AGE_BITS        = 32;
    localparam int SETTLE_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ID_POOL_TOP     = 23;

    typedef struct packed {
        logic [7:0]  res_id;
        logic        res_valid;
        logic        loading_blocked;
        logic [7:0]  pending_count;
        logic [31:0] current_time;
        logic [15:0] pinned_mask;
        logic [15:0] slot_busy_mask;
        logic        requester_busy;
    } req_beat_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [0:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_wdata;

    rsc_req_if req_ch ();
    rsc_rsp_if rsp_ch ();

    resource_slot_cache_oldest_replace_unit #(
        .SLOTS    (SLOTS),
        .ID_BITS  (ID_BITS),
        .AGE_BITS (AGE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // shadow copy of the cache and its registers
    logic        shadow_valid [SLOTS];
    logic [7:0]  shadow_id    [SLOTS];
    logic [31:0] shadow_age   [SLOTS];
    logic [7:0]  limit_shadow;
    logic [7:0]  bypass_shadow;

    rsc_result_t slot_results_q [$];
    int          fail_count;
    int          idle_pct;
    int          stall_pct;
    int          idle_cycles;
    logic [31:0] time_base;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic rsc_result_t resolve_slot(input req_beat_t b);
        rsc_result_t r;
        int          pick;
        logic [31:0] best;
        r = '0;
        if (b.res_id == bypass_shadow)
        begin
            r.slot_index = 5'(SLOTS);
            return r;
        end
        if (!b.res_valid)
        begin
            r.failed = 1'b1;
            return r;
        end
        for (int s = 0; s < SLOTS; s++)
        begin
            if (shadow_valid[s] && shadow_id[s] == b.res_id)
            begin
                r.slot_index     = 5'(s);
                r.hit            = 1'b1;
                r.clear_req_slot = !b.requester_busy;
                return r;
            end
        end
        r.miss_seen = 1'b1;
        if (b.loading_blocked || b.pending_count >= limit_shadow)
        begin
            r.failed = 1'b1;
            return r;
        end
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!shadow_valid[s])
            begin
                shadow_valid[s]  = 1'b1;
                shadow_id[s]     = b.res_id;
                shadow_age[s]    = b.current_time;
                r.slot_index     = 5'(s);
                r.loaded         = 1'b1;
                r.clear_req_slot = !b.requester_busy;
                return r;
            end
        end
        // strict compare keeps the lowest slot on equal ages
        pick = -1;
        best = AGE_LIMIT;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!b.pinned_mask[s] && shadow_age[s] < best)
            begin
                best = shadow_age[s];
                pick = s;
            end
        end
        if (pick < 0 || b.slot_busy_mask[pick])
        begin
            r.failed = 1'b1;
            return r;
        end
        shadow_valid[pick] = 1'b1;
        shadow_id[pick]    = b.res_id;
        shadow_age[pick]   = b.current_time;
        r.slot_index       = 5'(pick);
        r.loaded           = 1'b1;
        r.evicted          = 1'b1;
        r.clear_req_slot   = 1'b1;
        r.clear_req_busy   = 1'b1;
        return r;
    endfunction

    function automatic req_beat_t make_req(input logic [7:0] id, input logic valid,
                                           input logic blocked, input logic [7:0] pending,
                                           input logic [31:0] stamp, input logic [15:0] pinned,
                                           input logic [15:0] busy, input logic req_busy);
        req_beat_t b;
        b.res_id          = id;
        b.res_valid       = valid;
        b.loading_blocked = blocked;
        b.pending_count   = pending;
        b.current_time    = stamp;
        b.pinned_mask     = pinned;
        b.slot_busy_mask  = busy;
        b.requester_busy  = req_busy;
        return b;
    endfunction

    function automatic req_beat_t random_request();
        req_beat_t b;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            b.res_id = bypass_shadow;
        else if (pick < 65)
            b.res_id = 8'($urandom_range(0, ID_POOL_TOP));
        else
            b.res_id = 8'($urandom_range(0, 255));
        b.res_valid       = ($urandom_range(0, 99) < 92);
        b.loading_blocked = ($urandom_range(0, 99) < 8);
        if (limit_shadow != 0 && $urandom_range(0, 99) < 70)
            b.pending_count = 8'($urandom_range(0, limit_shadow - 1));
        else
            b.pending_count = 8'($urandom_range(0, 255));
        // ages mostly rise and stay replaceable; rarely one lands above the age limit
        pick = $urandom_range(0, 399);
        if (pick == 0)
            b.current_time = $urandom;
        else if (pick < 60)
            b.current_time = $urandom_range(0, time_base);
        else
        begin
            time_base      = time_base + $urandom_range(0, 40);
            b.current_time = time_base;
        end
        case ($urandom_range(0, 9))
            0:       b.pinned_mask = 16'hFFFF;
            1:       b.pinned_mask = 16'($urandom);
            default: b.pinned_mask = 16'($urandom & $urandom & $urandom);
        endcase
        if ($urandom_range(0, 9) == 0)
            b.slot_busy_mask = 16'($urandom);
        else
            b.slot_busy_mask = 16'($urandom & $urandom & $urandom);
        b.requester_busy = 1'($urandom);
        return b;
    endfunction

    task automatic send_request(input req_beat_t b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.res_id          <= b.res_id;
        req_ch.res_valid       <= b.res_valid;
        req_ch.loading_blocked <= b.loading_blocked;
        req_ch.pending_count   <= b.pending_count;
        req_ch.current_time    <= b.current_time;
        req_ch.pinned_mask     <= b.pinned_mask;
        req_ch.slot_busy_mask  <= b.slot_busy_mask;
        req_ch.requester_busy  <= b.requester_busy;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        slot_results_q.push_back(resolve_slot(b));
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (slot_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] limit, input logic [7:0] byp);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PENDING_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_index <= CFG_BYPASS_ID;
        cfg_wdata <= byp;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        limit_shadow  = limit;
        bypass_shadow = byp;
    endtask

    task automatic run_random_requests(input int count);
        for (int n = 0; n < count; n++)
            send_request(random_request());
    endtask

    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        // bypass wins over an invalid resource
        send_request(make_req(8'h1F, 1'b0, 1'b0, 8'd0, 32'd1, 16'h0, 16'h0, 1'b0));
        send_request(make_req(8'd5, 1'b0, 1'b0, 8'd0, 32'd1, 16'h0, 16'h0, 1'b0));
        send_request(make_req(8'd5, 1'b1, 1'b1, 8'd0, 32'd1, 16'h0, 16'h0, 1'b0));
        send_request(make_req(8'd5, 1'b1, 1'b0, 8'd10, 32'd1, 16'h0, 16'h0, 1'b0));
        send_request(make_req(8'd5, 1'b1, 1'b0, 8'd9, 32'd100, 16'h0, 16'h0, 1'b0));
        send_request(make_req(8'd5, 1'b1, 1'b0, 8'd0, 32'd100, 16'h0, 16'h0, 1'b1));
        // ages at and above the age limit are never chosen for replacement
        send_request(make_req(8'd0, 1'b1, 1'b0, 8'd0, AGE_LIMIT, 16'h0, 16'h0, 1'b1));
        send_request(make_req(8'd255, 1'b1, 1'b0, 8'd0, 32'hFFFF_FFFF, 16'h0, 16'h0, 1'b0));
        for (int i = 3; i < SLOTS; i++)
            send_request(make_req(8'(37 + i), 1'b1, 1'b0, 8'd0,
                                  (i == 3 || i == 4) ? 32'd50 : 32'(200 + i),
                                  16'h0, 16'h0, 1'(i)));
        // all replaceable slots pinned, the rest too old
        send_request(make_req(8'd99, 1'b1, 1'b0, 8'd0, 32'd300, 16'hFFF9, 16'h0, 1'b0));
        // oldest slot busy
        send_request(make_req(8'd99, 1'b1, 1'b0, 8'd0, 32'd300, 16'h0, 16'h0008, 1'b0));
        // oldest pinned, tie partner taken
        send_request(make_req(8'd99, 1'b1, 1'b0, 8'd0, 32'd300, 16'h0008, 16'h0, 1'b0));
        send_request(make_req(8'd98, 1'b1, 1'b0, 8'd0, 32'd310, 16'h0, 16'hFFF7, 1'b1));
        time_base = 32'd400;
    endtask

    task automatic test_default_config_stream();
        set_config(PENDING_LIMIT_RST, BYPASS_ID_RST);
        idle_pct  = 0;
        stall_pct = 0;
        run_random_requests(400);
    endtask

    task automatic test_zero_limit_sender_gaps();
        set_config(8'd0, 8'd0);
        idle_pct  = 69;
        stall_pct = 0;
        run_random_requests(250);
    endtask

    task automatic test_full_limit_receiver_stalls();
        set_config(8'd255, 8'd255);
        idle_pct  = 0;
        stall_pct = 69;
        run_random_requests(200);
        wait_all_results();
        run_random_requests(200);
    endtask

    task automatic test_mixed_idle();
        set_config(8'($urandom_range(1, 254)), 8'($urandom_range(0, 255)));
        idle_pct  = 22;
        stall_pct = 22;
        run_random_requests(475);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_rsp
        rsc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (slot_results_q.size() == 0)
            begin
                $error("result beat with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = slot_results_q.pop_front();
                check_field("slot_index", want.slot_index, rsp_ch.slot_index);
                check_field("failed", want.failed, rsp_ch.failed);
                check_field("hit", want.hit, rsp_ch.hit);
                check_field("loaded", want.loaded, rsp_ch.loaded);
                check_field("evicted", want.evicted, rsp_ch.evicted);
                check_field("miss_seen", want.miss_seen, rsp_ch.miss_seen);
                check_field("clear_req_slot", want.clear_req_slot, rsp_ch.clear_req_slot);
                check_field("clear_req_busy", want.clear_req_busy, rsp_ch.clear_req_busy);
            end
        end
    end

    // counts cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_PENDING_LIMIT;
        cfg_wdata              = '0;
        req_ch.valid           = 1'b0;
        req_ch.res_id          = '0;
        req_ch.res_valid       = 1'b0;
        req_ch.loading_blocked = 1'b0;
        req_ch.pending_count   = '0;
        req_ch.current_time    = '0;
        req_ch.pinned_mask     = '0;
        req_ch.slot_busy_mask  = '0;
        req_ch.requester_busy  = 1'b0;
        rsp_ch.ready           = 1'b0;
        fail_count             = 0;
        idle_pct               = 0;
        stall_pct              = 0;
        idle_cycles            = 0;
        time_base              = '0;
        limit_shadow           = PENDING_LIMIT_RST;
        bypass_shadow          = BYPASS_ID_RST;
        for (int s = 0; s < SLOTS; s++)
        begin
            shadow_valid[s] = 1'b0;
            shadow_id[s]    = '0;
            shadow_age[s]   = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_default_config_stream();
        test_zero_limit_sender_gaps();
        test_full_limit_receiver_stalls();
        test_mixed_idle();
        wait_all_results();

        if (fail_count == 0 && slot_results_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
